@@ rtl/stsc_pkg.sv @@
// Package for the sorted table search and count block.
// Holds table sizes, item codes, sequencer step codes and the microcode table.
// No dependencies.
package stsc_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int WORD_W      = 32;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		STEP_IDLE  = 4'd0,
		STEP_PROBE = 4'd1,
		STEP_CMP   = 4'd2,
		STEP_LRD   = 4'd3,
		STEP_LCMP  = 4'd4,
		STEP_RRD   = 4'd5,
		STEP_RCMP  = 4'd6,
		STEP_HIT   = 4'd7,
		STEP_MISS  = 4'd8
	} step_t;

	// Branch condition tested in a step.
	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_QUERY,
		COND_EMPTY_RANGE,
		COND_LEFT_END,
		COND_RIGHT_END,
		COND_MATCH
	} cond_t;

	// Which address goes to the table read port.
	typedef enum logic [1:0] {
		RD_NONE,
		RD_MID,
		RD_LEFT,
		RD_RIGHT
	} rd_t;

	// Datapath update after a table word has come back.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_SEARCH,
		OP_LSCAN,
		OP_RSCAN
	} op_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_HIT,
		EMIT_MISS
	} emit_t;

	typedef struct packed {
		cond_t cond;
		step_t jump_true;
		step_t jump_false;
		rd_t   rd;
		op_t   op;
		emit_t emit;
	} ucode_t;

	// The query program. Each probe and each scan step takes an address step and a
	// compare step, because the table read is registered.
	function automatic ucode_t ucode_rom(step_t step);
		ucode_t w;
		unique case (step)
			STEP_IDLE:  w = '{COND_QUERY,       STEP_PROBE, STEP_IDLE, RD_NONE,  OP_NONE,   EMIT_NONE};
			STEP_PROBE: w = '{COND_EMPTY_RANGE, STEP_MISS,  STEP_CMP,  RD_MID,   OP_NONE,   EMIT_NONE};
			STEP_CMP:   w = '{COND_MATCH,       STEP_LRD,   STEP_PROBE, RD_NONE, OP_SEARCH, EMIT_NONE};
			STEP_LRD:   w = '{COND_LEFT_END,    STEP_RRD,   STEP_LCMP, RD_LEFT,  OP_NONE,   EMIT_NONE};
			STEP_LCMP:  w = '{COND_MATCH,       STEP_LRD,   STEP_RRD,  RD_NONE,  OP_LSCAN,  EMIT_NONE};
			STEP_RRD:   w = '{COND_RIGHT_END,   STEP_HIT,   STEP_RCMP, RD_RIGHT, OP_NONE,   EMIT_NONE};
			STEP_RCMP:  w = '{COND_MATCH,       STEP_RRD,   STEP_HIT,  RD_NONE,  OP_RSCAN,  EMIT_NONE};
			STEP_HIT:   w = '{COND_ALWAYS,      STEP_IDLE,  STEP_IDLE, RD_NONE,  OP_NONE,   EMIT_HIT};
			STEP_MISS:  w = '{COND_ALWAYS,      STEP_IDLE,  STEP_IDLE, RD_NONE,  OP_NONE,   EMIT_MISS};
			default:    w = '{COND_ALWAYS,      STEP_IDLE,  STEP_IDLE, RD_NONE,  OP_NONE,   EMIT_NONE};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/stsc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module stsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/sorted_table_search_count.sv @@
// Top level of the sorted table search and count block.
// Depends on stsc_pkg and stsc_ram.
//
// An item is taken on a rising edge with start high and busy low. An append
// (kind 0) writes value at the end of the table and a clear (kind 2) empties
// it; both give no result and leave busy low, so another item may follow at
// once. An append to a full table and an item of kind 3 are dropped. A query
// (kind 1) raises busy and runs a short microcode program: a binary search
// over the filled entries, then, on a hit, a scan to the left and one to the
// right of the hit to count equal words. The single table port with its
// registered read sets the pace: every probe and every scan beat takes an
// address step and a compare step. A search makes at most log2 of the fill
// plus one probes; a scan that stops at a table end skips the compare step
// there. The result is shown for exactly one cycle with done high; the
// receiver cannot stall it, and busy falls in that same cycle so the next
// item can be taken at once.
module sorted_table_search_count
	import stsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        kind,
	input  logic [WORD_W-1:0] value,
	output logic              done,
	output logic              found,
	output logic [ADDR_W-1:0] position,
	output logic [CNT_W-1:0]  occurrences
);

	// Sequencer state.
	step_t  upc_q, upc_next;
	ucode_t uword;
	logic   cond_true;

	// Datapath registers. The search range is kept as low and one past high,
	// the left scan as one past its next index, so that none needs a sign.
	logic [CNT_W-1:0]         fill_q;
	logic signed [WORD_W-1:0] key_q;
	logic [CNT_W-1:0]         low_q;
	logic [CNT_W-1:0]         hi_end_q;
	logic [ADDR_W-1:0]        mid_q;
	logic [ADDR_W-1:0]        left_end_q;
	logic [CNT_W-1:0]         right_q;
	logic [CNT_W-1:0]         cnt_q;

	logic                     accept;
	logic                     is_append, is_query, is_clear;
	logic [CNT_W:0]           mid_sum;
	logic [ADDR_W-1:0]        mid;
	logic [ADDR_W-1:0]        raddr;
	logic [WORD_W-1:0]        rdata;
	logic                     match, probe_gt;
	logic                     ram_we;

	assign busy      = (upc_q != STEP_IDLE);
	assign accept    = start && !busy;
	assign is_append = (kind == KIND_APPEND);
	assign is_query  = (kind == KIND_QUERY);
	assign is_clear  = (kind == KIND_CLEAR);
	assign ram_we    = accept && is_append && (fill_q < CNT_W'(TABLE_DEPTH));

	assign uword = ucode_rom(upc_q);

	// Midpoint of the live range; the range is not empty whenever it is used.
	assign mid_sum = {1'b0, low_q} + {1'b0, hi_end_q} - 1'b1;
	assign mid     = mid_sum[ADDR_W:1];

	assign match    = ($signed(rdata) == key_q);
	assign probe_gt = ($signed(rdata) > key_q);

	always_comb begin
		unique case (uword.rd)
			RD_MID:   raddr = mid;
			RD_LEFT:  raddr = left_end_q - 1'b1;
			RD_RIGHT: raddr = right_q[ADDR_W-1:0];
			default:  raddr = mid_q;
		endcase
	end

	stsc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Condition select and next step.
	always_comb begin
		unique case (uword.cond)
			COND_QUERY:       cond_true = accept && is_query;
			COND_EMPTY_RANGE: cond_true = (low_q >= hi_end_q);
			COND_LEFT_END:    cond_true = (left_end_q == '0);
			COND_RIGHT_END:   cond_true = (right_q >= fill_q);
			COND_MATCH:       cond_true = match;
			default:          cond_true = 1'b1;
		endcase
	end

	always_comb begin
		upc_next = cond_true ? uword.jump_true : uword.jump_false;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= STEP_IDLE;
			fill_q <= '0;
		end else begin
			upc_q <= upc_next;
			if (accept && is_clear) begin
				fill_q <= '0;
			end else if (ram_we) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Search and scan registers: payload, no reset needed.
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			key_q    <= value;
			low_q    <= '0;
			hi_end_q <= fill_q;
		end
		if (uword.rd == RD_MID) begin
			mid_q <= mid;
		end
		unique case (uword.op)
			OP_SEARCH: begin
				if (match) begin
					left_end_q <= mid_q;
					right_q    <= {{(CNT_W-ADDR_W){1'b0}}, mid_q} + 1'b1;
					cnt_q      <= CNT_W'(1);
				end else if (probe_gt) begin
					hi_end_q <= {{(CNT_W-ADDR_W){1'b0}}, mid_q};
				end else begin
					low_q <= {{(CNT_W-ADDR_W){1'b0}}, mid_q} + 1'b1;
				end
			end
			OP_LSCAN: begin
				if (match) begin
					left_end_q <= left_end_q - 1'b1;
					cnt_q      <= cnt_q + 1'b1;
				end
			end
			OP_RSCAN: begin
				if (match) begin
					right_q <= right_q + 1'b1;
					cnt_q   <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Result beat: registered, held for exactly one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (uword.emit != EMIT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		unique case (uword.emit)
			EMIT_HIT: begin
				found       <= 1'b1;
				position    <= mid_q;
				occurrences <= cnt_q;
			end
			EMIT_MISS: begin
				found       <= 1'b0;
				position    <= '0;
				occurrences <= '0;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_done_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(upc_q) == STEP_HIT || $past(upc_q) == STEP_MISS))
		else $error("result beat without an emitting step");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (position == '0 && occurrences == '0))
		else $error("miss beat carries non-zero fields");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (occurrences != '0))
		else $error("hit beat with zero occurrences");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_QUERY) |=> busy)
		else $error("query taken without raising busy");
`endif

endmodule

@@ tb/sv/tb_sorted_table_search_count.sv @@
// Self-checking testbench for sorted_table_search_count: appends, queries and clears.
// Depends on stsc_pkg for sizes and item codes, and on the block's RTL.
// A built-in search-and-count predictor scores every result the block emits.
module tb_sorted_table_search_count;
	timeunit 1ns;
	timeprecision 1ps;

	import stsc_pkg::*;

	// The package names three item codes; the fourth code must be dropped by the block.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
	// Least number of counted beats (appends, queries and clears) to send.
	localparam int ITEMS_TOTAL = 1450;
	// Counted beats at the tail of the run that go out without any gaps.
	localparam int TAIL_NO_GAPS = 200;

	typedef struct {
		logic [1:0]        kind;
		logic [WORD_W-1:0] value;
		int                gap;
	} beat_t;

	typedef struct {
		logic              found;
		logic [ADDR_W-1:0] position;
		logic [CNT_W-1:0]  occurrences;
	} lookup_t;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	logic [1:0]        kind   = 2'd0;
	logic [WORD_W-1:0] value  = '0;
	logic              busy;
	logic              done;
	logic              found;
	logic [ADDR_W-1:0] position;
	logic [CNT_W-1:0]  occurrences;

	// Beats waiting to be offered, and the lookup results the block still owes us.
	beat_t   beats_to_send[$];
	lookup_t lookups_due[$];

	// Our own view of the table, updated on every accepted beat.
	logic [WORD_W-1:0] table_words[TABLE_DEPTH];
	int                table_fill = 0;

	// Stimulus-side copy of the table contents, used to pick query keys and to decide when a clear is due.
	int gen_words[$];
	int n_items   = 0;
	bit quiet     = 1'b0;
	int errors    = 0;
	int idle_left = 0;

	sorted_table_search_count uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.value       (value),
		.done        (done),
		.found       (found),
		.position    (position),
		.occurrences (occurrences)
	);

	always #2 clk = ~clk;

	// Binary search with midpoint (low + high) / 2 over the filled entries, compared as
	// signed words. On a hit the run of equal words either side of the hit is counted,
	// and the scans stop at both ends of the filled part of the table.
	function automatic lookup_t search_and_count(input logic [WORD_W-1:0] key);
		int      lo;
		int      hi;
		int      mid;
		int      hit;
		int      l;
		int      r;
		lookup_t res;
		lo  = 0;
		hi  = table_fill - 1;
		hit = -1;
		while (lo <= hi && hit < 0) begin
			mid = (lo + hi) / 2;
			if (table_words[mid] == key) begin
				hit = mid;
			end else if ($signed(table_words[mid]) > $signed(key)) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		res.found       = 1'b0;
		res.position    = '0;
		res.occurrences = '0;
		if (hit >= 0) begin
			l = hit - 1;
			r = hit + 1;
			while (l >= 0 && table_words[l] == key)
				l--;
			while (r < table_fill && table_words[r] == key)
				r++;
			res.found       = 1'b1;
			res.position    = ADDR_W'(hit);
			res.occurrences = CNT_W'(r - l - 1);
		end
		return res;
	endfunction

	// Applies one accepted beat to our table and queues the result a query must give.
	// An append to a full table and the unused code change nothing.
	function automatic void take_beat(input logic [1:0] k, input logic [WORD_W-1:0] v);
		case (k)
			KIND_APPEND: begin
				if (table_fill < TABLE_DEPTH) begin
					table_words[table_fill] = v;
					table_fill++;
				end
			end
			KIND_CLEAR:  table_fill = 0;
			KIND_QUERY:  lookups_due.push_back(search_and_count(v));
			default:     ;
		endcase
	endfunction

	// Queues one beat for the driver, with a random idle burst in front of it unless
	// the current stretch is quiet or we are in the gap-free tail of the run.
	task automatic add_beat(input logic [1:0] k, input logic [WORD_W-1:0] v);
		beat_t b;
		b.kind  = k;
		b.value = v;
		if (quiet || n_items >= ITEMS_TOTAL - TAIL_NO_GAPS || $urandom_range(0, 4) != 0)
			b.gap = 0;
		else
			b.gap = $urandom_range(1, 17);
		beats_to_send.push_back(b);
		if (k != KIND_UNUSED)
			n_items++;
		if (k == KIND_APPEND && gen_words.size() < TABLE_DEPTH)
			gen_words.push_back(int'(v));
		if (k == KIND_CLEAR)
			gen_words.delete();
	endtask

	// One full table: a long run of equal words topped by the largest word, then
	// appends that must be dropped, then queries that reach the top index and the
	// longest scans.
	task automatic fill_whole_table();
		int base;
		add_beat(KIND_CLEAR, $urandom);
		base = int'($urandom_range(0, 2000)) - 1000;
		for (int i = 0; i < TABLE_DEPTH - 1; i++)
			add_beat(KIND_APPEND, base);
		add_beat(KIND_APPEND, WORD_MAX);
		repeat (6) add_beat(KIND_APPEND, $urandom);
		add_beat(KIND_QUERY, base);
		add_beat(KIND_QUERY, WORD_MAX);
		add_beat(KIND_QUERY, base - 1);
		add_beat(KIND_QUERY, base + 1);
		add_beat(KIND_QUERY, WORD_MIN);
		add_beat(KIND_QUERY, WORD_MAX - 1);
	endtask

	// A short well-formed sequence with random content: usually a clear, a handful of
	// appends (mostly sorted, sometimes not) and a few queries that mostly hit.
	task automatic random_sequence();
		int batch[$];
		int n;
		int style;
		int pick;
		int key;
		quiet = ($urandom_range(0, 3) == 0);
		if (gen_words.size() > TABLE_DEPTH - 40 || $urandom_range(0, 3) != 0)
			add_beat(KIND_CLEAR, $urandom);
		n     = $urandom_range(0, 20);
		style = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			case (style)
				0:       batch.push_back(int'($urandom_range(0, 12)) - 6);
				1:       batch.push_back(int'($urandom));
				2:       batch.push_back(int'($urandom_range(0, 3)) * 1000);
				default: begin
					pick = $urandom_range(0, 5);
					if (pick == 0)      batch.push_back(int'(WORD_MIN));
					else if (pick == 1) batch.push_back(int'(WORD_MAX));
					else if (pick == 2) batch.push_back(-1);
					else if (pick == 3) batch.push_back(0);
					else if (pick == 4) batch.push_back(2);
					else                batch.push_back(int'($urandom));
				end
			endcase
		end
		// Now and then the fill is left unsorted, so the search takes odd turns.
		if ($urandom_range(0, 7) != 0)
			batch.sort();
		foreach (batch[i])
			add_beat(KIND_APPEND, batch[i]);
		if ($urandom_range(0, 9) == 0)
			add_beat(KIND_UNUSED, $urandom);
		repeat ($urandom_range(1, 6)) begin
			pick = $urandom_range(0, 9);
			if (gen_words.size() != 0 && pick < 8) begin
				key = gen_words[$urandom_range(0, gen_words.size() - 1)];
				// Neighbours of stored words are the likeliest near misses.
				if (pick == 6)      key = key + 1;
				else if (pick == 7) key = key - 1;
			end else begin
				key = int'($urandom);
			end
			add_beat(KIND_QUERY, key);
		end
	endtask

	// Driver: a beat is taken on an edge where start is high and busy is low. After
	// that the next beat is either offered at once or held back for its idle burst.
	// While the block is busy an offered beat simply waits with start high.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				take_beat(kind, value);
				beats_to_send.delete(0);
				if (beats_to_send.size() != 0)
					idle_left = beats_to_send[0].gap;
			end
			if (start && busy) begin
				// The offered beat stays on the ports until the block takes it.
			end else if (idle_left > 0) begin
				start <= 1'b0;
				idle_left--;
			end else if (beats_to_send.size() != 0) begin
				start <= 1'b1;
				kind  <= beats_to_send[0].kind;
				value <= beats_to_send[0].value;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: done marks a result for exactly one cycle and cannot be held off, so
	// every edge with done high is a result to score against the oldest query.
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && done) begin
			if (lookups_due.size() == 0) begin
				errors++;
				$display("%0t: result with no query outstanding: found %0d position %0d occurrences %0d",
					$time, found, position, occurrences);
			end else begin
				want = lookups_due.pop_front();
				if (found !== want.found) begin
					errors++;
					$display("%0t: found mismatch: expected %0d, actual %0d",
						$time, want.found, found);
				end
				if (position !== want.position) begin
					errors++;
					$display("%0t: position mismatch: expected %0d, actual %0d",
						$time, want.position, position);
				end
				if (occurrences !== want.occurrences) begin
					errors++;
					$display("%0t: occurrences mismatch: expected %0d, actual %0d",
						$time, want.occurrences, occurrences);
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int  drain;
		bit  full_done;
		full_done = 1'b0;

		// Directed part, all gap-free: an empty-table query, the extreme and constant
		// words with a run of duplicates, hits and misses, the unused code, a clear,
		// and a small unsorted fill.
		quiet = 1'b1;
		add_beat(KIND_QUERY, 32'd5);
		add_beat(KIND_APPEND, WORD_MIN);
		add_beat(KIND_APPEND, 32'hFFFF_FFFF);
		add_beat(KIND_APPEND, 32'd0);
		add_beat(KIND_APPEND, 32'd2);
		add_beat(KIND_APPEND, 32'd2);
		add_beat(KIND_APPEND, 32'd2);
		add_beat(KIND_APPEND, WORD_MAX);
		add_beat(KIND_QUERY, WORD_MIN);
		add_beat(KIND_QUERY, 32'hFFFF_FFFF);
		add_beat(KIND_QUERY, 32'd0);
		add_beat(KIND_QUERY, 32'd2);
		add_beat(KIND_QUERY, WORD_MAX);
		add_beat(KIND_QUERY, 32'd1);
		add_beat(KIND_QUERY, WORD_MAX - 1);
		add_beat(KIND_UNUSED, 32'hFFFF_FFFF);
		add_beat(KIND_CLEAR, 32'd0);
		add_beat(KIND_QUERY, 32'd2);
		add_beat(KIND_APPEND, 32'd5);
		add_beat(KIND_APPEND, 32'd1);
		add_beat(KIND_APPEND, 32'd5);
		add_beat(KIND_QUERY, 32'd5);
		add_beat(KIND_QUERY, 32'd1);

		// Random part, with one full table somewhere in the middle.
		while (n_items < ITEMS_TOTAL) begin
			if (!full_done && n_items >= 300) begin
				quiet = 1'b0;
				fill_whole_table();
				full_done = 1'b1;
			end else begin
				random_sequence();
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_to_send.size() != 0)
			@(posedge clk);
		// The longest query scans the whole table, one word after another.
		drain = 0;
		while (lookups_due.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (64) @(posedge clk);
		if (lookups_due.size() != 0) begin
			errors += lookups_due.size();
			$display("%0t: %0d query results never arrived", $time, lookups_due.size());
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog, set far beyond a run in which every beat is a whole-table query.
	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/stsc_pkg.sv
rtl/stsc_ram.sv
rtl/sorted_table_search_count.sv
tb/sv/tb_sorted_table_search_count.sv
